// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file teq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define TEQ_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define TEQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/teq_pkg.sv =====
// Shared types, constants and gain lookup for the three-band equalizer.
`default_nettype none

package teq_pkg;

    localparam int DEF_TAP_COUNT  = 256;
    localparam int DEF_BAND_COUNT = 3;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int GAIN_IDX_W  = 4;
    localparam int GAIN_BANDS  = 3;
    localparam int PROD_W      = 32;
    localparam int Q_SHIFT     = 15;
    localparam int ROUND_HALF  = 16384;
    localparam int PIPE_DRAIN  = 4;

    localparam int S_TDATA_W   = 64;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    typedef logic [CFG_INDEX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_FILTER_ENABLE = 2'd0;
    localparam cfg_idx_t CFG_BAND1_GAIN    = 2'd1;
    localparam cfg_idx_t CFG_BAND2_GAIN    = 2'd2;
    localparam cfg_idx_t CFG_BAND3_GAIN    = 2'd3;

    localparam logic KIND_COEF = 1'b0;
    localparam logic KIND_PAIR = 1'b1;

    typedef logic [GAIN_IDX_W-1:0] gain_idx_t;
    typedef logic [GAIN_W-1:0]     gain_t;

    localparam gain_idx_t GAIN_UNITY   = 4'd4;
    localparam gain_idx_t GAIN_MAX_IDX = 4'd8;

    // -12 dB .. +12 dB in 3 dB steps, Q15, linear gain divided by four
    localparam gain_t GAIN_TABLE [9] = '{
        16'h080A, 16'h0B5B, 16'h100A, 16'h16A7, 16'h2000,
        16'h2D34, 16'h3FD9, 16'h5A30, 16'h7F65
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_WR,
        ST_HIST_WR,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                       valid;
        logic signed [COEF_W-1:0]   tap;
    } tap_beat_t;

    // Saturate an out-of-range index to the top gain.
    function automatic gain_t gain_lookup(input gain_idx_t idx);
        gain_idx_t sel;
        sel = (idx > GAIN_MAX_IDX) ? GAIN_MAX_IDX : idx;
        return GAIN_TABLE[sel];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/teq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module teq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/teq_tap_mix.sv =====
// Band mixer: scales each base coefficient by its band gain and sums the bands.
`default_nettype none

module teq_tap_mix #(
    parameter int BAND_COUNT = teq_pkg::DEF_BAND_COUNT
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        in_valid,
    input  wire logic [BAND_COUNT*teq_pkg::COEF_W-1:0]       coef_row,
    input  wire logic [BAND_COUNT*teq_pkg::GAIN_IDX_W-1:0]   gain_sel,
    output teq_pkg::tap_beat_t                               tap_out
);
    import teq_pkg::*;

    logic signed [PROD_W-1:0] prod_reg  [BAND_COUNT];
    logic signed [PROD_W-1:0] prod_next [BAND_COUNT];
    logic                     prod_valid_reg;
    logic signed [COEF_W-1:0] tap_sum;
    tap_beat_t                tap_reg;

    // One 16 x 17 product per band lane.
    always_comb begin
        for (int b = 0; b < BAND_COUNT; b++) begin
            prod_next[b] = PROD_W'($signed(coef_row[b*COEF_W +: COEF_W]))
                         * PROD_W'($signed({1'b0,
                               gain_lookup(gain_sel[b*GAIN_IDX_W +: GAIN_IDX_W])}));
        end
    end

    // Shift right, truncate each term, wrap the sum.
    always_comb begin
        tap_sum = '0;
        for (int b = 0; b < BAND_COUNT; b++) begin
            tap_sum = tap_sum + prod_reg[b][COEF_W+Q_SHIFT-1:Q_SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg    <= prod_next;
        tap_reg.tap <= tap_sum;
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            tap_reg.valid  <= 1'b0;
        end else begin
            prod_valid_reg <= in_valid;
            tap_reg.valid  <= prod_valid_reg;
        end
    end

    assign tap_out = tap_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/three_band_fir_equalizer_unit.sv =====
// Top level of the stereo three-band FIR equalizer.
// Filtered pair: stored in the history ring, then one tap per cycle in ST_RUN, pipeline drain in
// ST_DRAIN, rounding in ST_FINISH and output in ST_EMIT; the next item is taken back in ST_IDLE.
// Bypassed pair or coefficient load: no new item is taken until the block is back in ST_IDLE.
// A stalled result holds off the next item; the tap loop reads one row and one pair per cycle.
// Reset clears control, histories read as zero through a fill count; coefficients stay unknown.
`default_nettype none

module three_band_fir_equalizer_unit #(
    parameter int TAP_COUNT  = teq_pkg::DEF_TAP_COUNT,
    parameter int BAND_COUNT = teq_pkg::DEF_BAND_COUNT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // item input
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // band[1:0], tap_index[9:2], coef_value[25:10], sample_left[41:26],
    // sample_right[57:42], zero fill[63:58]
    input  wire logic [teq_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind[0]
    input  wire logic [teq_pkg::S_TUSER_W-1:0]     s_tuser,
    // result output
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_left[15:0], out_right[31:16]
    output logic      [teq_pkg::M_TDATA_W-1:0]     m_tdata,
    // register writes
    input  wire logic                              cfg_we,
    input  wire logic [teq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [teq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import teq_pkg::*;

    localparam int AW     = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int KW     = $clog2(TAP_COUNT + 1);
    localparam int ROW_W  = BAND_COUNT * COEF_W;
    localparam int PAIR_W = 2 * SAMPLE_W;
    localparam int ACC_W  = PROD_W + 1 + KW;
    localparam int RND_W  = ACC_W + 1;
    localparam int DW     = $clog2(PIPE_DRAIN);

    // ------------------------------------------------------------------
    // Field unpacking
    // ------------------------------------------------------------------
    logic                  in_kind;
    logic [1:0]            in_band;
    logic [7:0]            in_tap;
    logic [COEF_W-1:0]     in_coef;
    logic [SAMPLE_W-1:0]   in_left;
    logic [SAMPLE_W-1:0]   in_right;
    logic                  in_accept;
    logic                  in_range;

    assign in_kind  = s_tuser[0];
    assign in_band  = s_tdata[1:0];
    assign in_tap   = s_tdata[9:2];
    assign in_coef  = s_tdata[25:10];
    assign in_left  = s_tdata[41:26];
    assign in_right = s_tdata[57:42];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       filter_enable_reg;
    gain_idx_t  gain_reg [GAIN_BANDS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_enable_reg <= 1'b0;
            for (int g = 0; g < GAIN_BANDS; g++) begin
                gain_reg[g] <= GAIN_UNITY;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FILTER_ENABLE: filter_enable_reg <= cfg_wdata[0];
                CFG_BAND1_GAIN:    gain_reg[0] <= cfg_wdata;
                CFG_BAND2_GAIN:    gain_reg[1] <= cfg_wdata;
                CFG_BAND3_GAIN:    gain_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Bands without a gain register run at unity gain.
    logic [BAND_COUNT*GAIN_IDX_W-1:0] gain_sel;

    for (genvar b = 0; b < BAND_COUNT; b++) begin : g_gain
        if (b < GAIN_BANDS) begin : g_reg
            assign gain_sel[b*GAIN_IDX_W +: GAIN_IDX_W] = gain_reg[b];
        end else begin : g_unity
            assign gain_sel[b*GAIN_IDX_W +: GAIN_IDX_W] = GAIN_UNITY;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [KW-1:0]       tap_cnt_reg;
    logic [KW-1:0]       fill_reg;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       hist_addr_reg;
    logic [DW-1:0]       drain_reg;
    logic                issue_reg;
    logic                tap_live_reg;
    logic                mul_valid_reg;
    logic                m_tvalid_reg;
    tap_beat_t           tap_beat;

    // payload holding registers
    logic [1:0]          band_reg;
    logic [AW-1:0]       tap_addr_reg;
    logic [COEF_W-1:0]   coef_reg;
    logic [PAIR_W-1:0]   res_reg;
    logic [PAIR_W-1:0]   m_data_reg;

    logic                out_free;
    logic                last_tap;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_tap  = (tap_cnt_reg == KW'(TAP_COUNT - 1));
    assign in_range  = (32'(in_band) < BAND_COUNT) && (32'(in_tap) < TAP_COUNT);
    assign in_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_kind == KIND_COEF) begin
                        // drop loads outside the tables
                        state_next = in_range ? ST_LOAD_WR : ST_IDLE;
                    end else if (filter_enable_reg) begin
                        state_next = ST_HIST_WR;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_LOAD_WR: state_next = ST_IDLE;
            ST_HIST_WR: state_next = ST_RUN;
            ST_RUN: begin
                if (last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_reg == '0) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs: memory strobes and addresses
    // ------------------------------------------------------------------
    logic                coef_we;
    logic [AW-1:0]       coef_raddr;
    logic [ROW_W-1:0]    coef_wdata;
    logic [ROW_W-1:0]    coef_rdata;
    logic                hist_we;
    logic [PAIR_W-1:0]   hist_rdata;
    logic                issue;
    logic                out_load;

    always_comb begin
        coef_we    = 1'b0;
        hist_we    = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        s_tready   = 1'b0;
        coef_raddr = tap_cnt_reg[AW-1:0];
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                // fetch the row that a load is about to patch
                coef_raddr = AW'(in_tap);
            end
            ST_LOAD_WR: coef_we  = 1'b1;
            ST_HIST_WR: hist_we  = 1'b1;
            ST_RUN:     issue    = 1'b1;
            ST_EMIT:    out_load = out_free;
            default: ;
        endcase
    end

    // Patch one band slice of the row read back in the previous cycle.
    always_comb begin
        coef_wdata = coef_rdata;
        for (int b = 0; b < BAND_COUNT; b++) begin
            if (32'(band_reg) == b) begin
                coef_wdata[b*COEF_W +: COEF_W] = coef_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Memories: coefficient rows (all bands of one tap) and sample pairs
    // ------------------------------------------------------------------
    teq_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TAP_COUNT)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (tap_addr_reg),
        .wdata (coef_wdata),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    teq_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (TAP_COUNT)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (ptr_reg),
        .wdata (res_reg),
        .raddr (hist_addr_reg),
        .rdata (hist_rdata)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tap_cnt_reg   <= '0;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            hist_addr_reg <= '0;
            drain_reg     <= '0;
            issue_reg     <= 1'b0;
            tap_live_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            issue_reg    <= issue;
            // taps older than the samples seen so far read as zero history
            tap_live_reg <= (tap_cnt_reg < fill_reg);
            mul_valid_reg <= tap_beat.valid;

            case (state_reg)
                ST_HIST_WR: begin
                    hist_addr_reg <= ptr_reg;
                    ptr_reg       <= (ptr_reg == AW'(TAP_COUNT - 1)) ? '0 : ptr_reg + 1'b1;
                    if (fill_reg != KW'(TAP_COUNT)) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    tap_cnt_reg   <= '0;
                end
                ST_RUN: begin
                    tap_cnt_reg   <= tap_cnt_reg + 1'b1;
                    // walk back through the history ring
                    hist_addr_reg <= (hist_addr_reg == '0) ? AW'(TAP_COUNT - 1)
                                                           : hist_addr_reg - 1'b1;
                    drain_reg     <= DW'(PIPE_DRAIN - 1);
                end
                ST_DRAIN: drain_reg <= drain_reg - 1'b1;
                default: ;
            endcase

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Band mixing of one coefficient row into one effective tap
    // ------------------------------------------------------------------
    teq_tap_mix #(
        .BAND_COUNT (BAND_COUNT)
    ) u_tap_mix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (issue_reg),
        .coef_row (coef_rdata),
        .gain_sel (gain_sel),
        .tap_out  (tap_beat)
    );

    // ------------------------------------------------------------------
    // Sample alignment, tap products and accumulation
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] xl2_reg, xr2_reg, xl3_reg, xr3_reg;
    logic signed [PROD_W-1:0]   ml_reg, mr_reg;
    logic signed [ACC_W-1:0]    acc_l_reg, acc_r_reg;

    always_ff @(posedge aclk) begin
        // delay the samples through xl2/xr2 and xl3/xr3 to meet the mixed tap
        xl2_reg <= tap_live_reg ? hist_rdata[SAMPLE_W-1:0] : '0;
        xr2_reg <= tap_live_reg ? hist_rdata[PAIR_W-1:SAMPLE_W] : '0;
        xl3_reg <= xl2_reg;
        xr3_reg <= xr2_reg;
        ml_reg  <= PROD_W'(tap_beat.tap) * PROD_W'(xl3_reg);
        mr_reg  <= PROD_W'(tap_beat.tap) * PROD_W'(xr3_reg);

        if (state_reg == ST_HIST_WR) begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else if (mul_valid_reg) begin
            acc_l_reg <= acc_l_reg + ACC_W'(ml_reg);
            acc_r_reg <= acc_r_reg + ACC_W'(mr_reg);
        end
    end

    // ------------------------------------------------------------------
    // Round to nearest, shift down and saturate to 16 bits
    // ------------------------------------------------------------------
    logic signed [RND_W-1:0]    rnd_l, rnd_r;
    logic        [SAMPLE_W-1:0] sat_l, sat_r;
    logic                       fit_l, fit_r;

    always_comb begin
        rnd_l = RND_W'(acc_l_reg) + RND_W'(ROUND_HALF);
        rnd_r = RND_W'(acc_r_reg) + RND_W'(ROUND_HALF);
        // fits when every bit above the result's sign agrees with it
        fit_l = (&rnd_l[RND_W-1:SAMPLE_W+Q_SHIFT-1]) || !(|rnd_l[RND_W-1:SAMPLE_W+Q_SHIFT-1]);
        fit_r = (&rnd_r[RND_W-1:SAMPLE_W+Q_SHIFT-1]) || !(|rnd_r[RND_W-1:SAMPLE_W+Q_SHIFT-1]);
        sat_l = fit_l ? rnd_l[SAMPLE_W+Q_SHIFT-1:Q_SHIFT]
                      : (rnd_l[RND_W-1] ? 16'h8000 : 16'h7FFF);
        sat_r = fit_r ? rnd_r[SAMPLE_W+Q_SHIFT-1:Q_SHIFT]
                      : (rnd_r[RND_W-1] ? 16'h8000 : 16'h7FFF);
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            band_reg     <= in_band;
            tap_addr_reg <= AW'(in_tap);
            coef_reg     <= in_coef;
            // bypass result, and the pair to store in the history ring
            res_reg      <= {in_right, in_left};
        end else if (state_reg == ST_FINISH) begin
            res_reg      <= {sat_r, sat_l};
        end
        if (out_load) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/teq_checker.sv =====
// Port-level checker for the equalizer, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module teq_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [teq_pkg::S_TUSER_W-1:0]   s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [teq_pkg::M_TDATA_W-1:0]   m_tdata
);
    import teq_pkg::*;

    logic load_in;
    logic pair_in;

    assign load_in = s_tvalid && s_tready && (s_tuser[0] == KIND_COEF);
    assign pair_in = s_tvalid && s_tready && (s_tuser[0] == KIND_PAIR);

    `TEQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `TEQ_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    `TEQ_ASSERT_NEXT(a_load_silent, aclk, aresetn, load_in, !$rose(m_tvalid), "coefficient load raised a result")
    `TEQ_ASSERT_NEXT(a_pair_busy, aclk, aresetn, pair_in, !s_tready, "input still open after a sample pair")

endmodule

bind three_band_fir_equalizer_unit teq_checker u_teq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== bench/tb_three_band_fir_equalizer_unit.sv =====
// Self-checking testbench for the stereo three-band FIR equalizer.
`timescale 1ns / 100ps

module tb_three_band_fir_equalizer_unit;
    import teq_pkg::*;

    localparam int     TAPS          = 256;
    localparam int     BANDS         = 3;
    localparam longint CYCLE_LIMIT   = 3_000_000;
    localparam int     LOAD_SETTLE   = 8;     // covers the time a coefficient load keeps the block busy
    localparam int     FILTER_SETTLE = 300;   // covers the return of a filtered pair
    localparam int     RANDOM_ROUNDS = 13;
    localparam int     ROUND_ITEMS   = 90;

    typedef logic signed [15:0] sample_t;

    typedef struct {
        logic       kind;
        logic [1:0] band;
        logic [7:0] tap;
        sample_t    coef;
        sample_t    left;
        sample_t    right;
    } eq_item_t;

    typedef struct {
        sample_t left;
        sample_t right;
    } stereo_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    three_band_fir_equalizer_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Equalizer shadow state: base tables, gains, bypass flag and histories
    sample_t    base_coef [BANDS][TAPS];
    logic [3:0] band_gain [BANDS];
    logic       filter_on;
    sample_t    hist_left  [TAPS];
    sample_t    hist_right [TAPS];
    logic [7:0] hist_ptr;

    stereo_t expected_pairs [$];

    bit     idling_on = 1'b1;
    int     ready_stall;
    int     error_count;
    longint cycle_count;
    int     n_loads, n_ignored, n_filtered, n_bypassed;

    // Q15 gain for an index; indexes above eight clamp to +12 dB
    function automatic longint gain_q15(input logic [3:0] idx);
        case (idx)
            4'd0:    return 64'sh080A;
            4'd1:    return 64'sh0B5B;
            4'd2:    return 64'sh100A;
            4'd3:    return 64'sh16A7;
            4'd4:    return 64'sh2000;
            4'd5:    return 64'sh2D34;
            4'd6:    return 64'sh3FD9;
            4'd7:    return 64'sh5A30;
            default: return 64'sh7F65;
        endcase
    endfunction

    // Effective tap: per-band scaled terms truncated to 16 bits, summed with wrap
    function automatic sample_t mixed_tap(input int k);
        logic [15:0] sum;
        longint      q;
        sum = '0;
        for (int b = 0; b < BANDS; b++) begin
            q   = (longint'(base_coef[b][k]) * gain_q15(band_gain[b])) >>> 15;
            sum = sum + q[15:0];
        end
        return sample_t'(sum);
    endfunction

    function automatic sample_t round_saturate(input longint acc);
        longint y;
        y = (acc + 64'sd16384) >>> 15;
        if (y > 64'sd32767)
            y = 64'sd32767;
        if (y < -64'sd32768)
            y = -64'sd32768;
        return sample_t'(y[15:0]);
    endfunction

    // Run one pair through the FIR and advance the history pointer
    function automatic stereo_t equalize_pair(input sample_t left, input sample_t right);
        longint     acc_l, acc_r;
        sample_t    h;
        logic [7:0] pos;
        stereo_t    res;
        hist_left[hist_ptr]  = left;
        hist_right[hist_ptr] = right;
        acc_l = 0;
        acc_r = 0;
        for (int k = 0; k < TAPS; k++) begin
            h     = mixed_tap(k);
            pos   = hist_ptr - 8'(k);
            acc_l += longint'(h) * longint'(hist_left[pos]);
            acc_r += longint'(h) * longint'(hist_right[pos]);
        end
        hist_ptr  = hist_ptr + 8'd1;
        res.left  = round_saturate(acc_l);
        res.right = round_saturate(acc_r);
        return res;
    endfunction

    // Update shadow state for an accepted item and queue the result it causes
    function automatic void predict_item(input eq_item_t it);
        stereo_t res;
        if (it.kind == KIND_COEF) begin
            n_loads++;
            if (it.band < BANDS)
                base_coef[it.band][it.tap] = it.coef;
            else
                n_ignored++;
        end else if (!filter_on) begin
            n_bypassed++;
            res.left  = it.left;
            res.right = it.right;
            expected_pairs.push_back(res);
        end else begin
            n_filtered++;
            expected_pairs.push_back(equalize_pair(it.left, it.right));
        end
    endfunction

    // Mostly uniform random values, with full-scale and near-zero values mixed in
    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3:    return sample_t'(int'($urandom_range(0, 511)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Coefficient with a random magnitude range so outputs do not always clip
    function automatic sample_t rand_coef();
        int m;
        m = $urandom_range(4, 15);
        return sample_t'(int'($urandom_range(0, (1 << (m + 1)) - 1)) - (1 << m));
    endfunction

    function automatic logic [3:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return 4'd0;
            1:       return 4'd8;
            2:       return 4'd15;
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic eq_item_t make_item(input logic kind, input logic [1:0] band,
                                           input logic [7:0] tap, input sample_t coef,
                                           input sample_t left, input sample_t right);
        eq_item_t it;
        it.kind  = kind;
        it.band  = band;
        it.tap   = tap;
        it.coef  = coef;
        it.left  = left;
        it.right = right;
        return it;
    endfunction

    // Present one item, hold it until accepted, then maybe idle for a burst
    task automatic send_item(input eq_item_t it);
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {6'b0, it.right, it.left, it.coef, it.tap, it.band};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_item(it);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    // Drop valid and wait for the block to drain before touching registers
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge aclk);
        repeat (LOAD_SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [3:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_FILTER_ENABLE: filter_on    = value[0];
            CFG_BAND1_GAIN:    band_gain[0] = value;
            CFG_BAND2_GAIN:    band_gain[1] = value;
            CFG_BAND3_GAIN:    band_gain[2] = value;
            default: ;
        endcase
    endtask

    task automatic write_config(input logic enable, input logic [3:0] g1,
                                input logic [3:0] g2, input logic [3:0] g3);
        write_reg(CFG_FILTER_ENABLE, {3'b0, enable});
        write_reg(CFG_BAND1_GAIN, g1);
        write_reg(CFG_BAND2_GAIN, g2);
        write_reg(CFG_BAND3_GAIN, g3);
        cfg_we <= 1'b0;
    endtask

    task automatic reset_dut();
        for (int b = 0; b < BANDS; b++) begin
            band_gain[b] = GAIN_UNITY;
            for (int k = 0; k < TAPS; k++)
                base_coef[b][k] = '0;
        end
        for (int k = 0; k < TAPS; k++) begin
            hist_left[k]  = '0;
            hist_right[k] = '0;
        end
        hist_ptr  = '0;
        filter_on = 1'b0;
        aresetn   = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    endtask

    // Out of reset the block bypasses: full-scale pairs and loads to the missing band
    task automatic test_bypass_extremes();
        send_item(make_item(KIND_PAIR, 2'd0, 8'd0, 16'sh0000, 16'sh8000, 16'sh7FFF));
        send_item(make_item(KIND_PAIR, 2'd3, 8'hFF, 16'shFFFF, 16'sh7FFF, 16'sh8000));
        send_item(make_item(KIND_COEF, 2'd3, 8'hFF, 16'shFFFF, 16'shFFFF, 16'shFFFF));
        send_item(make_item(KIND_COEF, 2'd3, 8'h00, 16'sh0000, 16'sh0000, 16'sh0000));
        send_item(make_item(KIND_PAIR, 2'd1, 8'h55, 16'sh5555, 16'sh0000, 16'shFFFF));
        send_item(make_item(KIND_PAIR, 2'd2, 8'hAA, 16'shAAAA, 16'sh5555, 16'shAAAA));
    endtask

    // Write every tap of every band so filtering never reads an unwritten entry
    task automatic test_table_load();
        for (int b = 0; b < BANDS; b++)
            for (int k = 0; k < TAPS; k++)
                send_item(make_item(KIND_COEF, 2'(b), 8'(k), rand_coef(),
                                    rand_sample(), rand_sample()));
    endtask

    // Tap order via an impulse, history frozen in bypass, clamped and extreme gains
    task automatic test_gain_and_history();
        send_item(make_item(KIND_COEF, 2'd0, 8'd0, 16'sh7FFF, 16'sh0000, 16'sh0000));
        send_item(make_item(KIND_COEF, 2'd2, 8'd255, 16'sh8000, 16'sh0000, 16'sh0000));
        wait_idle();
        write_config(1'b1, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY);
        send_item(make_item(KIND_PAIR, 2'd0, 8'd0, 16'sh0000, 16'sh7FFF, 16'sh8000));
        repeat (3)
            send_item(make_item(KIND_PAIR, 2'd0, 8'd0, 16'sh0000, 16'sh0000, 16'sh0000));
        wait_idle();
        write_config(1'b0, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY);
        send_item(make_item(KIND_PAIR, 2'd0, 8'd0, 16'sh0000, 16'sh1234, 16'shEDCB));
        send_item(make_item(KIND_PAIR, 2'd0, 8'd0, 16'sh0000, 16'sh7FFF, 16'sh7FFF));
        wait_idle();
        write_config(1'b1, 4'd15, 4'd0, 4'd9);
        send_item(make_item(KIND_PAIR, 2'd0, 8'd0, 16'sh0000, 16'sh7FFF, 16'sh8000));
        send_item(make_item(KIND_PAIR, 2'd0, 8'd0, 16'sh0000, 16'sh8000, 16'sh7FFF));
        wait_idle();
        write_config(1'b1, GAIN_MAX_IDX, GAIN_MAX_IDX, GAIN_MAX_IDX);
        send_item(make_item(KIND_PAIR, 2'd0, 8'd0, 16'sh0000, 16'sh8000, 16'sh8000));
    endtask

    // Rounds of random settings, each followed by mostly pairs and some reloads
    task automatic test_random_traffic();
        eq_item_t it;
        for (int r = 0; r < RANDOM_ROUNDS; r++) begin
            if (r >= RANDOM_ROUNDS - 2)
                idling_on = 1'b0;
            wait_idle();
            write_config($urandom_range(0, 3) != 0, rand_gain(), rand_gain(), rand_gain());
            for (int i = 0; i < ROUND_ITEMS; i++) begin
                it = make_item($urandom_range(0, 4) != 0 ? KIND_PAIR : KIND_COEF,
                               2'($urandom_range(0, 3)), 8'($urandom), rand_coef(),
                               rand_sample(), rand_sample());
                send_item(it);
            end
        end
    endtask

    // Receiver: random stall bursts, always ready once idling is off
    always @(posedge aclk) begin
        if (ready_stall > 0) begin
            ready_stall = ready_stall - 1;
            m_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            ready_stall = $urandom_range(0, 14);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result against the oldest queued pair
    always @(posedge aclk) begin : check_result
        stereo_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pairs.size() == 0) begin
                error_count++;
                $error("result with none expected: m_tdata=%h", m_tdata);
            end else begin
                want = expected_pairs.pop_front();
                if (m_tdata[15:0] !== want.left) begin
                    error_count++;
                    $error("out_left: expected %0d, actual %0d", want.left,
                           $signed(m_tdata[15:0]));
                end
                if (m_tdata[31:16] !== want.right) begin
                    error_count++;
                    $error("out_right: expected %0d, actual %0d", want.right,
                           $signed(m_tdata[31:16]));
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[three_band_fir_equalizer_unit] ERROR");
            $finish;
        end
    end

    initial begin
        reset_dut();
        test_bypass_extremes();
        test_table_load();
        test_gain_and_history();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge aclk);
        repeat (FILTER_SETTLE) @(posedge aclk);
        if (expected_pairs.size() != 0) begin
            error_count++;
            $error("%0d results never arrived", expected_pairs.size());
        end

        $display("Covered %0d coefficient loads (%0d to the absent band), %0d filtered pairs,",
                 n_loads, n_ignored, n_filtered);
        $display("%0d bypassed pairs across gain settings 0..15 and both filter modes.",
                 n_bypassed);
        if (error_count == 0) begin
            $display("[three_band_fir_equalizer_unit] OK");
        end else begin
            $display("[three_band_fir_equalizer_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/teq_pkg.sv
hw/rtl/teq_ram.sv
hw/rtl/teq_tap_mix.sv
hw/rtl/three_band_fir_equalizer_unit.sv
hw/rtl/teq_checker.sv
bench/tb_three_band_fir_equalizer_unit.sv
